// File: sv/assert_macros.svh
// assertion macros shared by the led strip pulse encoder rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/lspe_pkg.sv
// types, constants and lookup tables of the led strip pulse encoder
// no dependencies; imported by every module of the block
package lspe_pkg;

   localparam int COLOR_W      = 8;
   localparam int HUE_W        = 16;
   localparam int HUE_MOD_W    = 9;
   localparam int TICKS_W      = 16;
   localparam int PERIODS_W    = 10;
   localparam int GRB_W        = 24;
   localparam int BIT_IDX_W    = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int SEG_W        = 3;
   localparam int REM_W        = 6;

   localparam int BITS_PER_LED = 24;
   localparam int HUE_RANGE    = 360;
   localparam int SEG_DEG      = 60;
   localparam int SEG_COUNT    = 6;
   localparam int COLOR_MAX    = 255;
   localparam int HUE_LO_SPAN  = 256;

   localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = BIT_IDX_W'(BITS_PER_LED - 1);

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_PERIODS = 2'd2;

   localparam logic [TICKS_W-1:0]   ONE_HIGH_RESET      = 16'd150;
   localparam logic [TICKS_W-1:0]   ZERO_HIGH_RESET     = 16'd75;
   localparam logic [PERIODS_W-1:0] RESET_PERIODS_RESET = 10'd50;

   typedef struct packed {
      logic                 mode;
      logic [COLOR_W-1:0]   red;
      logic [COLOR_W-1:0]   green;
      logic [COLOR_W-1:0]   blue;
      logic [HUE_W-1:0]     hue;
      logic                 frame_last;
   } req_type;

   typedef struct packed {
      logic [TICKS_W-1:0]   compare_value;
      logic [PERIODS_W-1:0] low_period_count;
      logic                 is_reset;
      logic                 run_last;
   } rsp_type;

   // request after the hue has been folded below 360
   typedef struct packed {
      logic                 mode;
      logic [COLOR_W-1:0]   red;
      logic [COLOR_W-1:0]   green;
      logic [COLOR_W-1:0]   blue;
      logic [HUE_MOD_W-1:0] hue_mod;
      logic                 frame_last;
   } stage_type;

   typedef struct packed {
      logic [TICKS_W-1:0]   one_high_ticks;
      logic [TICKS_W-1:0]   zero_high_ticks;
      logic [PERIODS_W-1:0] reset_periods;
   } cfg_type;

   // (hi * 256) mod 360 for the upper hue byte
   typedef logic [HUE_MOD_W-1:0] hue_fold_tab_type [HUE_LO_SPAN];

   function automatic hue_fold_tab_type build_hue_fold();
      hue_fold_tab_type t;
      for (int i = 0; i < HUE_LO_SPAN; i++) begin
         t[i] = HUE_MOD_W'((i * HUE_LO_SPAN) % HUE_RANGE);
      end
      return t;
   endfunction

   localparam hue_fold_tab_type HUE_FOLD = build_hue_fold();

   // floor(255 * k / 60) for k = 0..60
   typedef logic [COLOR_W-1:0] ramp_tab_type [SEG_DEG + 1];

   function automatic ramp_tab_type build_ramp();
      ramp_tab_type t;
      for (int k = 0; k <= SEG_DEG; k++) begin
         t[k] = COLOR_W'((COLOR_MAX * k) / SEG_DEG);
      end
      return t;
   endfunction

   localparam ramp_tab_type RAMP = build_ramp();

endpackage

// File: sv/lspe_hue_stage.sv
// input register and hue fold stage of the led strip pulse encoder
// depends on lspe_pkg
module lspe_hue_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  lspe_pkg::req_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output lspe_pkg::stage_type out_data
);
   import lspe_pkg::*;

   logic      a_vld_ff, a_vld_in;
   req_type   a_ff, a_in;
   logic      b_vld_ff, b_vld_in;
   stage_type b_ff, b_in;

   logic                 b_take;
   logic [HUE_MOD_W:0]   fold_sum;
   logic [HUE_MOD_W-1:0] hue_mod;

   assign b_take   = a_vld_ff && (!b_vld_ff || out_ready);
   assign in_ready = !a_vld_ff || b_take;

   // hue = hi*256 + lo, hi*256 folded by table, then one correction
   always_comb begin
      fold_sum = {1'b0, HUE_FOLD[a_ff.hue[HUE_W-1:COLOR_W]]}
               + (HUE_MOD_W + 1)'(a_ff.hue[COLOR_W-1:0]);
      if (fold_sum >= (HUE_MOD_W + 1)'(HUE_RANGE)) begin
         hue_mod = HUE_MOD_W'(fold_sum - (HUE_MOD_W + 1)'(HUE_RANGE));
      end else begin
         hue_mod = HUE_MOD_W'(fold_sum);
      end
   end

   always_comb begin
      a_vld_in = a_vld_ff;
      a_in     = a_ff;
      if (in_valid && in_ready) begin
         a_vld_in = 1'b1;
         a_in     = in_data;
      end else if (b_take) begin
         a_vld_in = 1'b0;
      end

      b_vld_in = b_vld_ff;
      b_in     = b_ff;
      if (b_take) begin
         b_vld_in           = 1'b1;
         b_in.mode          = a_ff.mode;
         b_in.red           = a_ff.red;
         b_in.green         = a_ff.green;
         b_in.blue          = a_ff.blue;
         b_in.hue_mod       = hue_mod;
         b_in.frame_last    = a_ff.frame_last;
      end else if (out_ready) begin
         b_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign out_valid = b_vld_ff;
   assign out_data  = b_ff;

endmodule

// File: sv/lspe_color.sv
// color selection: hue segment and ramps, packed into a grb word
// depends on lspe_pkg
module lspe_color (
   input  lspe_pkg::stage_type          in_data,
   output logic [lspe_pkg::GRB_W-1:0]   grb
);
   import lspe_pkg::*;

   localparam logic [SEG_W-1:0] SEG_R_TO_Y = 3'd0;
   localparam logic [SEG_W-1:0] SEG_Y_TO_G = 3'd1;
   localparam logic [SEG_W-1:0] SEG_G_TO_C = 3'd2;
   localparam logic [SEG_W-1:0] SEG_C_TO_B = 3'd3;
   localparam logic [SEG_W-1:0] SEG_B_TO_M = 3'd4;

   localparam logic [COLOR_W-1:0] FULL = COLOR_W'(COLOR_MAX);
   localparam logic [COLOR_W-1:0] OFF  = '0;

   logic [SEG_W-1:0]     seg;
   logic [HUE_MOD_W-1:0] seg_base;
   logic [REM_W-1:0]     rem;
   logic [COLOR_W-1:0]   up;
   logic [COLOR_W-1:0]   down;
   logic [COLOR_W-1:0]   r;
   logic [COLOR_W-1:0]   g;
   logic [COLOR_W-1:0]   b;

   always_comb begin
      seg      = '0;
      seg_base = '0;
      for (int j = 1; j < SEG_COUNT; j++) begin
         if (in_data.hue_mod >= HUE_MOD_W'(j * SEG_DEG)) begin
            seg      = SEG_W'(j);
            seg_base = HUE_MOD_W'(j * SEG_DEG);
         end
      end
      rem  = REM_W'(in_data.hue_mod - seg_base);
      up   = RAMP[rem];
      down = RAMP[REM_W'(SEG_DEG) - rem];
   end

   always_comb begin
      if (in_data.mode) begin
         unique case (seg)
            SEG_R_TO_Y: begin r = FULL; g = up;   b = OFF;  end
            SEG_Y_TO_G: begin r = down; g = FULL; b = OFF;  end
            SEG_G_TO_C: begin r = OFF;  g = FULL; b = up;   end
            SEG_C_TO_B: begin r = OFF;  g = down; b = FULL; end
            SEG_B_TO_M: begin r = up;   g = OFF;  b = FULL; end
            default:    begin r = FULL; g = OFF;  b = down; end
         endcase
      end else begin
         r = in_data.red;
         g = in_data.green;
         b = in_data.blue;
      end
      grb = {g, r, b};
   end

endmodule

// File: sv/lspe_serializer.sv
// bit serializer and result register: one pulse result per cycle unless rsp
// stalls, latch reset result after a last led; depends on lspe_pkg, lspe_color
module lspe_serializer (
   input  logic                clock,
   input  logic                reset,
   input  lspe_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  lspe_pkg::stage_type in_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lspe_pkg::rsp_type   rsp_data
);
   import lspe_pkg::*;

   logic [GRB_W-1:0] grb;

   logic                 c_vld_ff, c_vld_in;
   logic [GRB_W-1:0]     word_ff, word_in;
   logic [BIT_IDX_W-1:0] idx_ff, idx_in;
   logic                 last_ff, last_in;
   logic                 rst_phase_ff, rst_phase_in;

   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;

   logic    out_free;
   logic    emit;
   logic    done;
   rsp_type cur;

   lspe_color u_color (
      .in_data (in_data),
      .grb     (grb)
   );

   assign out_free = !rsp_vld_ff || rsp_ready;
   assign emit     = c_vld_ff && out_free;
   assign done     = emit && (rst_phase_ff || (idx_ff == '0 && !last_ff));
   assign in_ready = !c_vld_ff || done;

   always_comb begin
      if (rst_phase_ff) begin
         cur.compare_value    = '0;
         cur.low_period_count = cfg.reset_periods;
         cur.is_reset         = 1'b1;
         cur.run_last         = 1'b1;
      end else begin
         cur.compare_value    = word_ff[GRB_W-1] ? cfg.one_high_ticks
                                                 : cfg.zero_high_ticks;
         cur.low_period_count = '0;
         cur.is_reset         = 1'b0;
         cur.run_last         = (idx_ff == '0) && !last_ff;
      end
   end

   always_comb begin
      c_vld_in     = c_vld_ff;
      word_in      = word_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      rst_phase_in = rst_phase_ff;
      if (in_valid && in_ready) begin
         c_vld_in     = 1'b1;
         word_in      = grb;
         idx_in       = LAST_BIT_IDX;
         last_in      = in_data.frame_last;
         rst_phase_in = 1'b0;
      end else if (done) begin
         c_vld_in = 1'b0;
      end else if (emit) begin
         // after bit zero of a frame's last led comes the reset result
         if (idx_ff == '0) begin
            rst_phase_in = 1'b1;
         end else begin
            word_in = {word_ff[GRB_W-2:0], 1'b0};
            idx_in  = idx_ff - 1'b1;
         end
      end

      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (out_free) begin
         rsp_vld_in = c_vld_ff;
         rsp_in     = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         c_vld_ff   <= c_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      rst_phase_ff <= rst_phase_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/led_strip_pulse_encoder.sv
// top level of the led strip pulse encoder: control registers and stage wiring
// depends on lspe_pkg, lspe_hue_stage, lspe_serializer, assert_macros.svh
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   req     | req_valid/req_ready  | req_data: mode, rgb, hue, last
//   rsp     | rsp_valid/rsp_ready  | rsp_data: compare, count, flags
//   csr     | csr_valid/csr_ready  | csr_index, csr_data
//
// one result per cycle unless rsp stalls: 24 results per led, plus the reset
// result when frame_last is set, from the serializer's bit counter; requests
// overlap so the next led starts on the cycle after the previous one ends.
// a request passes the input, hue fold, serializer word and result registers.
// reset is synchronous and restores 150 / 75 / 50; a stalled rsp holds the
// whole pipe, csr writes are taken every cycle.
`include "assert_macros.svh"

module led_strip_pulse_encoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  lspe_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output lspe_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lspe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lspe_pkg::TICKS_W-1:0]         csr_data
);
   import lspe_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      ser_valid;
   logic      ser_ready;
   stage_type ser_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ONE_HIGH:      cfg_in.one_high_ticks  = csr_data;
            CSR_ZERO_HIGH:     cfg_in.zero_high_ticks = csr_data;
            CSR_RESET_PERIODS: cfg_in.reset_periods   = csr_data[PERIODS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high_ticks  <= ONE_HIGH_RESET;
         cfg_ff.zero_high_ticks <= ZERO_HIGH_RESET;
         cfg_ff.reset_periods   <= RESET_PERIODS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lspe_hue_stage u_hue_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (ser_valid),
      .out_ready (ser_ready),
      .out_data  (ser_data)
   );

   lspe_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (ser_valid),
      .in_ready  (ser_ready),
      .in_data   (ser_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // the reset result always closes its run and drives no high time
   `ASSERT_IMPLY(a_reset_result_form, clock, reset, rsp_valid && rsp_data.is_reset, rsp_data.run_last && rsp_data.compare_value == '0)
   // data bits always carry a zero period count
   `ASSERT_IMPLY(a_data_no_count, clock, reset, rsp_valid && !rsp_data.is_reset, rsp_data.low_period_count == '0)
   // within one led's run the results come without gaps
   `ASSERT_NEXT(a_run_no_gap, clock, reset, rsp_valid && rsp_ready && !rsp_data.run_last, rsp_valid)

endmodule
